>>> hw/rtl/rle_grid_pkg.sv
// ----------------------------------------------------------------------------
// rle_grid_pkg
// Shared types and constants of the RLE pattern grid loader: the request and
// result payloads, the opcodes, the body characters and the register map.
// ----------------------------------------------------------------------------
package rle_grid_pkg;

  // Default side of the largest grid held in memory.
  localparam int MAX_SIDE_DEFAULT = 256;

  // Width and reset value of the grid side register.
  localparam int              GRID_SIDE_W     = 9;
  localparam logic [8:0]      GRID_SIDE_RESET = 9'd256;

  // Register indexes (word addresses on the configuration port).
  localparam logic            REG_GRID_SIDE = 1'b0;

  // Width of the run count and of the cursor, and its saturation value.
  localparam int              RUN_W   = 16;
  localparam logic [15:0]     RUN_MAX = 16'hFFFF;

  // Opcodes of a request.
  localparam logic [1:0]      OP_CHAR  = 2'd0;
  localparam logic [1:0]      OP_CLEAR = 2'd1;
  localparam logic [1:0]      OP_READ  = 2'd2;

  // Body characters.
  localparam logic [7:0]      CHAR_DEAD = 8'h62;  // 'b'
  localparam logic [7:0]      CHAR_LIVE = 8'h6F;  // 'o'
  localparam logic [7:0]      CHAR_ROW  = 8'h24;  // '$'
  localparam logic [7:0]      CHAR_END  = 8'h21;  // '!'
  localparam logic [7:0]      CHAR_ZERO = 8'h30;  // '0'
  localparam logic [7:0]      CHAR_NINE = 8'h39;  // '9'

  // One request.
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [7:0] read_row;
    logic [7:0] read_col;
  } req_t;

  // One result.
  typedef struct packed {
    logic cell_value;
    logic decode_finished;
  } rsp_t;

endpackage

>>> hw/rtl/rle_pattern_grid_loader_top.sv
// ----------------------------------------------------------------------------
// rle_pattern_grid_loader_top
// Decodes the body of a run-length-encoded cellular-automaton pattern into a
// square grid of one-bit cells held in a row-wide memory, and reads cells back.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Character and read
// requests keep busy high only while they execute; a read answers with
// result_valid high for exactly one cycle, the cycle after acceptance, and
// the receiver cannot stall it, so it must take the result in that cycle. A
// run of 'b' or 'o' writes all of its cells in one masked row write, so its
// length does not change the timing. A clear sweeps the grid memory one row
// per cycle and keeps busy high until its last row is written. The
// grid is undefined after reset: issue a clear before the first character or
// read. Configuration writes are taken at any time and complete at once.
// ----------------------------------------------------------------------------
module rle_pattern_grid_loader_top #(
  parameter int MAX_SIDE = rle_grid_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  // Request channel
  input  logic                start,
  output logic                busy,
  input  rle_grid_pkg::req_t  request,
  // Result channel
  output logic                result_valid,
  output rle_grid_pkg::rsp_t  result,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Row address width and width of a side value.
  localparam int AW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = (SW > rle_grid_pkg::GRID_SIDE_W) ? SW : rle_grid_pkg::GRID_SIDE_W;
  localparam int RW = (SW > 8) ? SW : 8;
  localparam int UW = rle_grid_pkg::RUN_W;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  logic [1:0]                          state;
  logic [1:0]                          state_next;
  rle_grid_pkg::req_t                  req;
  logic [rle_grid_pkg::GRID_SIDE_W-1:0] grid_side;
  logic [UW-1:0]                       pending_run;
  logic [UW-1:0]                       pending_run_next;
  logic [UW-1:0]                       cursor_col;
  logic [UW-1:0]                       cursor_col_next;
  logic [UW-1:0]                       cursor_row;
  logic [UW-1:0]                       cursor_row_next;
  logic                                end_seen;
  logic                                end_seen_next;
  logic [AW-1:0]                       sweep;

  // Grid memory: one row per entry, one bit per cell.
  logic [MAX_SIDE-1:0]                 grid [MAX_SIDE];
  logic [MAX_SIDE-1:0]                 rd_data;
  logic                                wr_en;
  logic [AW-1:0]                       wr_row;
  logic [MAX_SIDE-1:0]                 wr_mask;
  logic                                wr_bit;

  logic                                accept;
  logic                                cfg_write;
  logic [SW-1:0]                       eff_side;
  logic [UW-1:0]                       side_ext;
  logic [UW-1:0]                       step_count;
  logic [UW:0]                         col_sum;
  logic [UW:0]                         row_sum;
  logic [19:0]                         digit_sum;
  logic [SW-1:0]                       run_lo;
  logic [SW-1:0]                       run_hi;
  logic                                is_digit;
  logic                                in_grid;
  logic                                rd_in_range;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // Configuration register and read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= rle_grid_pkg::GRID_SIDE_RESET;
    end else if (cfg_write && paddr[2] == rle_grid_pkg::REG_GRID_SIDE) begin
      grid_side <= pwdata[rle_grid_pkg::GRID_SIDE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == rle_grid_pkg::REG_GRID_SIDE) ?
                  32'(grid_side) : 32'd0;

  // The side in use never exceeds the memory.
  always_comb begin
    if (CW'(grid_side) > CW'(MAX_SIDE)) begin
      eff_side = SW'(MAX_SIDE);
    end else begin
      eff_side = SW'(grid_side);
    end
  end
  assign side_ext = UW'(eff_side);

  // Run arithmetic: count, saturating cursor moves, decimal accumulation.
  assign step_count = (pending_run == '0) ? UW'(1) : pending_run;
  assign col_sum    = (UW+1)'(cursor_col) + (UW+1)'(step_count);
  assign row_sum    = (UW+1)'(cursor_row) + (UW+1)'(step_count);
  assign digit_sum  = (20'(pending_run) << 3) + (20'(pending_run) << 1) +
                      20'(req.char_code[3:0]);
  assign is_digit   = (req.char_code >= rle_grid_pkg::CHAR_ZERO) &&
                      (req.char_code <= rle_grid_pkg::CHAR_NINE);
  assign in_grid    = (cursor_row < side_ext) && (cursor_col < side_ext);

  // Span of the run inside the current row, clipped to the side.
  assign run_lo = SW'(cursor_col);
  assign run_hi = (col_sum > (UW+1)'(eff_side)) ? eff_side : SW'(col_sum);

  // Sequencer and decoder state.
  always_comb begin
    state_next       = state;
    pending_run_next = pending_run;
    cursor_col_next  = cursor_col;
    cursor_row_next  = cursor_row;
    end_seen_next    = end_seen;
    wr_en            = 1'b0;
    wr_row           = cursor_row[AW-1:0];
    wr_mask          = ({MAX_SIDE{1'b1}} << run_lo) & ~({MAX_SIDE{1'b1}} << run_hi);
    wr_bit           = (req.char_code == rle_grid_pkg::CHAR_LIVE);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        case (req.opcode)
          rle_grid_pkg::OP_CHAR: begin
            if (!end_seen) begin
              if (is_digit) begin
                pending_run_next = (digit_sum > 20'(rle_grid_pkg::RUN_MAX)) ?
                                   rle_grid_pkg::RUN_MAX : digit_sum[UW-1:0];
              end else if (req.char_code == rle_grid_pkg::CHAR_DEAD ||
                           req.char_code == rle_grid_pkg::CHAR_LIVE) begin
                wr_en            = in_grid;
                cursor_col_next  = col_sum[UW] ? rle_grid_pkg::RUN_MAX : col_sum[UW-1:0];
                pending_run_next = '0;
              end else if (req.char_code == rle_grid_pkg::CHAR_ROW) begin
                cursor_row_next  = row_sum[UW] ? rle_grid_pkg::RUN_MAX : row_sum[UW-1:0];
                cursor_col_next  = '0;
                pending_run_next = '0;
              end else if (req.char_code == rle_grid_pkg::CHAR_END) begin
                end_seen_next = 1'b1;
              end
            end
          end
          rle_grid_pkg::OP_CLEAR: begin
            pending_run_next = '0;
            cursor_col_next  = '0;
            cursor_row_next  = '0;
            end_seen_next    = 1'b0;
            state_next       = ST_CLEAR;
          end
          default: begin
          end
        endcase
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_row  = sweep;
        wr_mask = '1;
        wr_bit  = 1'b0;
        if (sweep == AW'(MAX_SIDE - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pending_run <= '0;
      cursor_col  <= '0;
      cursor_row  <= '0;
      end_seen    <= 1'b0;
      sweep       <= '0;
    end else begin
      state       <= state_next;
      pending_run <= pending_run_next;
      cursor_col  <= cursor_col_next;
      cursor_row  <= cursor_row_next;
      end_seen    <= end_seen_next;
      if (state == ST_CLEAR) begin
        sweep <= sweep + AW'(1);
      end else begin
        sweep <= '0;
      end
    end
  end

  // Request capture; the range check of a read is taken along with it.
  always_ff @(posedge clk) begin
    if (accept) begin
      req         <= request;
      rd_in_range <= (RW'(request.read_row) < RW'(eff_side)) &&
                     (RW'(request.read_col) < RW'(eff_side));
    end
  end

  // Grid memory: masked row write, row read issued as the request is accepted.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_SIDE; i++) begin
      if (wr_en && wr_mask[i]) begin
        grid[wr_row][i] <= wr_bit;
      end
    end
    if (accept) begin
      rd_data <= grid[AW'(request.read_row)];
    end
  end

  // A read answers in the cycle after acceptance.
  assign result_valid           = (state == ST_EXEC) && (req.opcode == rle_grid_pkg::OP_READ);
  assign result.cell_value      = rd_in_range && rd_data[AW'(req.read_col)];
  assign result.decode_finished = end_seen;

endmodule
